FILE: sv/tbte_pkg.sv
// ----------------------------------------------------------------------------
// tbte_pkg: shared constants, types and functions
// Clamp limits, phase overheads, macro periods and their reciprocals, and
// the exponent/mantissa timeout encoding.
// ----------------------------------------------------------------------------
package tbte_pkg;

  localparam int unsigned BudgetMinMs = 15;
  localparam int unsigned BudgetMaxMs = 500;
  localparam int unsigned NsPerMs     = 1000000;
  localparam int unsigned OverheadANs = 1320;
  localparam int unsigned OverheadBNs = 960;

  localparam int unsigned BudgetW = 9;   // clamped budget, up to 500
  localparam int unsigned NsW     = 29;  // up to 5e8 ns
  localparam int unsigned PerW    = 17;  // largest period 124118
  localparam int unsigned RecShift = 40;
  localparam int unsigned RecW    = 25;  // 2^40 / 41373 < 2^25
  localparam int unsigned ProdW   = NsW + RecW;
  localparam int unsigned CountW  = 14;  // quotient up to about 12085
  localparam int unsigned WordW   = 16;

  localparam logic [PerW-1:0] PeriodShortA = 17'd57922;
  localparam logic [PerW-1:0] PeriodShortB = 17'd41373;
  localparam logic [PerW-1:0] PeriodLongA  = 17'd124118;
  localparam logic [PerW-1:0] PeriodLongB  = 17'd107569;

  // floor(2^40 / period): quotient estimate is exact or one low
  localparam logic [RecW-1:0] RecShortA = RecW'((64'd1 << RecShift) / 64'd57922);
  localparam logic [RecW-1:0] RecShortB = RecW'((64'd1 << RecShift) / 64'd41373);
  localparam logic [RecW-1:0] RecLongA  = RecW'((64'd1 << RecShift) / 64'd124118);
  localparam logic [RecW-1:0] RecLongB  = RecW'((64'd1 << RecShift) / 64'd107569);

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic logic [PerW-1:0] period_sel(input logic phase_b, input logic long_mode);
    logic [PerW-1:0] p;
    if (long_mode) p = phase_b ? PeriodLongB : PeriodLongA;
    else           p = phase_b ? PeriodShortB : PeriodShortA;
    return p;
  endfunction

  function automatic logic [RecW-1:0] recip_sel(input logic phase_b, input logic long_mode);
    logic [RecW-1:0] r;
    if (long_mode) r = phase_b ? RecLongB : RecLongA;
    else           r = phase_b ? RecShortB : RecShortA;
    return r;
  endfunction

  // exponent in the high byte, (count-1) shifted down to 8 bits in the low byte
  function automatic logic [WordW-1:0] encode_count(input logic [CountW-1:0] count);
    logic [CountW-1:0] m;
    logic [2:0]        expo;
    logic [CountW-1:0] mant;
    m    = count - CountW'(1);
    expo = 3'd0;
    for (int i = 8; i < CountW; i++) begin
      if (m[i]) expo = 3'(i - 7);
    end
    mant = m >> expo;
    if (count == '0) return '0;
    return {5'd0, expo, mant[7:0]};
  endfunction

endpackage

FILE: sv/timing_budget_timeout_encoder.sv
// ----------------------------------------------------------------------------
// timing_budget_timeout_encoder: budget to encoded phase A/B timeouts
// An input passes the front register, the divider stages and the word register before out_valid.
// Throughput: one item per cycle while out_ready holds; each stage holds on its own when stalled.
// Synchronous active-low reset clears valid bits and range_mode (short range).
// ----------------------------------------------------------------------------
module timing_budget_timeout_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_budget_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_timeout_word_a,
  output logic [15:0] out_timeout_word_b
);

  logic [1:0]  range_mode_r;
  logic [4:1]  v_r;
  logic [4:1]  v_nxt;
  logic        out_valid_r;
  logic        en1;
  logic        en5;
  tbte_pkg::stage_en_t en;

  logic [tbte_pkg::NsW-1:0]    ns_a;
  logic [tbte_pkg::NsW-1:0]    ns_b;
  logic                        long1;
  logic [tbte_pkg::CountW-1:0] count_a;
  logic [tbte_pkg::CountW-1:0] count_b;
  logic [15:0]                 word_a_r;
  logic [15:0]                 word_b_r;

  // each stage loads when empty or when its content moves on
  assign en5    = !out_valid_r || out_ready;
  assign en.s4  = !v_r[4] || en5;
  assign en.s3  = !v_r[3] || en.s4;
  assign en.s2  = !v_r[2] || en.s3;
  assign en1    = !v_r[1] || en.s2;
  assign in_ready = en1;

  always_comb begin
    v_nxt = v_r;
    if (en1)   v_nxt[1] = in_valid;
    if (en.s2) v_nxt[2] = v_r[1];
    if (en.s3) v_nxt[3] = v_r[2];
    if (en.s4) v_nxt[4] = v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_mode_r <= 2'd0;
      v_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) range_mode_r <= cfg_wdata;
      v_r <= v_nxt;
      if (en5) out_valid_r <= v_r[4];
    end
  end

  tbte_front u_front (
    .clk       (clk),
    .en        (en1),
    .budget_ms (in_budget_ms),
    .long_mode (range_mode_r != 2'd0),
    .ns_a_r    (ns_a),
    .ns_b_r    (ns_b),
    .long_r    (long1)
  );

  tbte_div u_div_a (
    .clk     (clk),
    .en      (en),
    .phase_b (1'b0),
    .long_in (long1),
    .ns_in   (ns_a),
    .count_r (count_a)
  );

  tbte_div u_div_b (
    .clk     (clk),
    .en      (en),
    .phase_b (1'b1),
    .long_in (long1),
    .ns_in   (ns_b),
    .count_r (count_b)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      word_a_r <= tbte_pkg::encode_count(count_a);
      word_b_r <= tbte_pkg::encode_count(count_b);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_timeout_word_a = word_a_r;
  assign out_timeout_word_b = word_b_r;

endmodule

FILE: sv/tbte_front.sv
// ----------------------------------------------------------------------------
// tbte_front: budget clamp and overhead subtract
// Clamps the budget to 15..500 ms, scales to ns and registers the two
// phase numerators with the range selection.
// ----------------------------------------------------------------------------
module tbte_front (
  input  logic                       clk,
  input  logic                       en,
  input  logic [15:0]                budget_ms,
  input  logic                       long_mode,
  output logic [tbte_pkg::NsW-1:0]   ns_a_r,
  output logic [tbte_pkg::NsW-1:0]   ns_b_r,
  output logic                       long_r
);

  logic [tbte_pkg::BudgetW-1:0] budget_c;
  logic [tbte_pkg::NsW-1:0]     ns;
  logic [tbte_pkg::NsW-1:0]     ns_a_nxt;
  logic [tbte_pkg::NsW-1:0]     ns_b_nxt;

  always_comb begin
    if (budget_ms < 16'(tbte_pkg::BudgetMinMs)) begin
      budget_c = tbte_pkg::BudgetW'(tbte_pkg::BudgetMinMs);
    end else if (budget_ms > 16'(tbte_pkg::BudgetMaxMs)) begin
      budget_c = tbte_pkg::BudgetW'(tbte_pkg::BudgetMaxMs);
    end else begin
      budget_c = budget_ms[tbte_pkg::BudgetW-1:0];
    end
    ns       = tbte_pkg::NsW'(budget_c) * tbte_pkg::NsW'(tbte_pkg::NsPerMs);
    ns_a_nxt = ns - tbte_pkg::NsW'(tbte_pkg::OverheadANs);
    ns_b_nxt = ns - tbte_pkg::NsW'(tbte_pkg::OverheadBNs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns_a_r <= ns_a_nxt;
      ns_b_r <= ns_b_nxt;
      long_r <= long_mode;
    end
  end

endmodule

FILE: sv/tbte_div.sv
// ----------------------------------------------------------------------------
// tbte_div: divide by selected macro period
// Three stages: reciprocal multiply, back-multiply by the period, then
// remainder check that bumps the estimate by one when needed.
// ----------------------------------------------------------------------------
module tbte_div (
  input  logic                          clk,
  input  tbte_pkg::stage_en_t           en,
  input  logic                          phase_b,
  input  logic                          long_in,
  input  logic [tbte_pkg::NsW-1:0]      ns_in,
  output logic [tbte_pkg::CountW-1:0]   count_r
);

  logic [tbte_pkg::NsW-1:0]    ns2_r;
  logic                        long2_r;
  logic [tbte_pkg::ProdW-1:0]  prod2_r;

  logic [tbte_pkg::NsW-1:0]    ns3_r;
  logic                        long3_r;
  logic [tbte_pkg::CountW-1:0] q3_r;
  logic [tbte_pkg::NsW-1:0]    qd3_r;

  logic [tbte_pkg::CountW-1:0] q3_nxt;
  logic [tbte_pkg::NsW-1:0]    rem4;
  logic [tbte_pkg::CountW-1:0] count_nxt;
  logic [tbte_pkg::PerW-1:0]   per3;

  assign q3_nxt = prod2_r[tbte_pkg::RecShift +: tbte_pkg::CountW];
  assign per3   = tbte_pkg::period_sel(phase_b, long3_r);
  assign rem4   = ns3_r - qd3_r;

  always_comb begin
    count_nxt = q3_r;
    // estimate is at most one low
    if (rem4 >= tbte_pkg::NsW'(per3)) count_nxt = q3_r + tbte_pkg::CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      ns2_r   <= ns_in;
      long2_r <= long_in;
      prod2_r <= tbte_pkg::ProdW'(ns_in) *
                 tbte_pkg::ProdW'(tbte_pkg::recip_sel(phase_b, long_in));
    end
    if (en.s3) begin
      ns3_r   <= ns2_r;
      long3_r <= long2_r;
      q3_r    <= q3_nxt;
      qd3_r   <= tbte_pkg::NsW'(q3_nxt) *
                 tbte_pkg::NsW'(tbte_pkg::period_sel(phase_b, long2_r));
    end
    if (en.s4) begin
      count_r <= count_nxt;
    end
  end

endmodule
